@@ rtl/ndpf_pkg.sv @@
// shared constants for the near duplicate plane filter
`default_nettype none

package ndpf_pkg;

  localparam int CFG_W = 23;
  localparam int LIMIT2_W = 2 * CFG_W;
  localparam int ANGLE_SHIFT = 44;

  localparam logic REG_DISTANCE_LIMIT = 1'b0;
  localparam logic REG_COS_ANGLE_LIMIT = 1'b1;

  localparam logic [CFG_W-1:0] COS_LIMIT_RESET = 23'd3941356;

endpackage

`default_nettype wire

@@ rtl/near_duplicate_plane_filter.sv @@
// top level: plane store, sequencer and duplicate tests for the plane filter
`default_nettype none

// A non-plane word goes from accept to S_DONE, which moves its result into the output
// register once that is free, and the block then takes the next word. A plane word
// first spends six multiplies on its own normal length, the two squared limits and the
// squared cosine limit times that length. It then runs up to thirteen multiplies and
// the compares against each kept plane in turn, and stops at the first match. Every
// multiply goes through one shared shift-add unit at one bit of the second operand per
// cycle. The result then waits in the output register until it is taken.

module near_duplicate_plane_filter
  import ndpf_pkg::*;
#(
  parameter int MAX_PLANES = 64,
  parameter int COORD_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         start_set,
  input  wire logic                         is_plane,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic signed [COORD_BITS-1:0] point_z,
  input  wire logic signed [COORD_BITS-1:0] normal_x,
  input  wire logic signed [COORD_BITS-1:0] normal_y,
  input  wire logic signed [COORD_BITS-1:0] normal_z,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              keep,
  output logic                              store_overflow
);

  localparam int C  = COORD_BITS;
  localparam int CW = $clog2(MAX_PLANES + 1);
  localparam int IW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int AW = LIMIT2_W + 2 * C;
  localparam int BW = 2 * C + 1;
  localparam int PW = AW + BW;
  localparam int DW = 2 * C + 2;
  localparam int LW = 4 * C + 2;
  localparam int RW = 6 * C;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NN   = 4'd1;
  localparam logic [3:0] S_DL2  = 4'd2;
  localparam logic [3:0] S_CL2  = 4'd3;
  localparam logic [3:0] S_T    = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_MM   = 4'd6;
  localparam logic [3:0] S_DD   = 4'd7;
  localparam logic [3:0] S_DD2  = 4'd8;
  localparam logic [3:0] S_RHS1 = 4'd9;
  localparam logic [3:0] S_NM   = 4'd10;
  localparam logic [3:0] S_NM2  = 4'd11;
  localparam logic [3:0] S_RHS2 = 4'd12;
  localparam logic [3:0] S_NEXT = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0]              state;
  logic [1:0]              k;
  logic                    wait_mul;
  logic [CW-1:0]           count;
  logic [CW-1:0]           idx;
  logic [CFG_W-1:0]        dist_lim;
  logic [CFG_W-1:0]        cos_lim;
  logic                    res_keep;
  logic                    res_ovf;
  logic signed [C-1:0]     p_r [3];
  logic signed [C-1:0]     n_r [3];
  logic [2*C-1:0]          nn;
  logic [2*C-1:0]          mm;
  logic [LIMIT2_W-1:0]     dl2;
  logic [LIMIT2_W-1:0]     cl2;
  logic [AW-1:0]           t_lim;
  logic signed [DW-1:0]    acc;
  logic [LW-1:0]           lhs;

  logic [RW-1:0]           mem [MAX_PLANES];
  logic [RW-1:0]           rd_q;
  logic [RW-1:0]           row_in;

  logic signed [C-1:0]     q_a [3];
  logic signed [C-1:0]     m_a [3];
  logic signed [C:0]       d_k;
  logic [C:0]              d_mag;
  logic [C-1:0]            m_mag;
  logic [C-1:0]            n_mag;
  logic [BW-1:0]           acc_mag;
  logic signed [DW-1:0]    acc_new;
  logic signed [DW-1:0]    term;
  logic                    mul_state;
  logic                    mul_start;
  logic                    mul_done;
  logic [AW-1:0]           mul_a;
  logic [BW-1:0]           mul_b;
  logic                    mul_neg;
  logic [PW-1:0]           prod;
  logic                    accept;
  logic                    finish;
  logic                    full;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (count == CW'(MAX_PLANES));

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      q_a[j] = rd_q[j*C +: C];
      m_a[j] = rd_q[(3+j)*C +: C];
    end
    row_in = {n_r[2], n_r[1], n_r[0], p_r[2], p_r[1], p_r[0]};
    d_k    = {p_r[k][C-1], p_r[k]} - {q_a[k][C-1], q_a[k]};
    d_mag  = d_k[C] ? (C+1)'(-d_k) : (C+1)'(d_k);
    m_mag  = m_a[k][C-1] ? C'(-m_a[k]) : C'(m_a[k]);
    n_mag  = n_r[k][C-1] ? C'(-n_r[k]) : C'(n_r[k]);
    acc_mag = acc[DW-1] ? BW'(-acc) : BW'(acc);
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state)
      S_NN: begin
        mul_a = AW'(n_mag);
        mul_b = BW'(n_mag);
      end
      S_DL2: begin
        mul_a = AW'(dist_lim);
        mul_b = BW'(dist_lim);
      end
      S_CL2: begin
        mul_a = AW'(cos_lim);
        mul_b = BW'(cos_lim);
      end
      S_T: begin
        mul_a = AW'(cl2);
        mul_b = BW'(nn);
      end
      S_MM: begin
        mul_a = AW'(m_mag);
        mul_b = BW'(m_mag);
      end
      S_DD: begin
        mul_a   = AW'(d_mag);
        mul_b   = BW'(m_mag);
        mul_neg = d_k[C] ^ m_a[k][C-1];
      end
      S_DD2, S_NM2: begin
        mul_a = AW'(acc_mag);
        mul_b = acc_mag;
      end
      S_RHS1: begin
        mul_a = AW'(dl2);
        mul_b = BW'(mm);
      end
      S_NM: begin
        mul_a   = AW'(n_mag);
        mul_b   = BW'(m_mag);
        mul_neg = n_r[k][C-1] ^ m_a[k][C-1];
      end
      S_RHS2: begin
        mul_a = t_lim;
        mul_b = BW'(mm);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_NN, S_DL2, S_CL2, S_T, S_MM, S_DD, S_DD2, S_RHS1, S_NM, S_NM2, S_RHS2:
        mul_state = 1'b1;
      default:
        mul_state = 1'b0;
    endcase
  end

  assign mul_start = mul_state && !wait_mul;

  ndpf_mul #(
    .AW(AW),
    .BW(BW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  always_comb begin
    term    = mul_neg ? -$signed(DW'(prod)) : $signed(DW'(prod));
    acc_new = ((k == 2'd0) ? DW'(0) : acc) + term;
    finish  = 1'b0;
    if (wait_mul && mul_done && state == S_T && count == '0) begin
      finish = 1'b1;
    end
    if (state == S_NEXT && (idx + CW'(1)) == count) begin
      finish = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_lim <= '0;
      cos_lim  <= COS_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DISTANCE_LIMIT:  dist_lim <= cfg_data;
        REG_COS_ANGLE_LIMIT: cos_lim  <= cfg_data;
        default:             dist_lim <= dist_lim;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (finish && !full) begin
      mem[count[IW-1:0]] <= row_in;
    end
    rd_q <= mem[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r[0] <= point_x;
      p_r[1] <= point_y;
      p_r[2] <= point_z;
      n_r[0] <= normal_x;
      n_r[1] <= normal_y;
      n_r[2] <= normal_z;
    end
    if (wait_mul && mul_done) begin
      case (state)
        S_NN:          nn    <= ((k == 2'd0) ? '0 : nn) + prod[2*C-1:0];
        S_DL2:         dl2   <= prod[LIMIT2_W-1:0];
        S_CL2:         cl2   <= prod[LIMIT2_W-1:0];
        S_T:           t_lim <= prod[AW-1:0];
        S_MM:          mm    <= ((k == 2'd0) ? '0 : mm) + prod[2*C-1:0];
        S_DD, S_NM:    acc   <= acc_new;
        S_DD2, S_NM2:  lhs   <= prod[LW-1:0];
        default:       lhs   <= lhs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      k              <= '0;
      wait_mul       <= 1'b0;
      count          <= '0;
      idx            <= '0;
      res_keep       <= 1'b1;
      res_ovf        <= 1'b0;
      out_valid      <= 1'b0;
      keep           <= 1'b1;
      store_overflow <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (mul_start) begin
        wait_mul <= 1'b1;
      end else if (mul_done) begin
        wait_mul <= 1'b0;
      end
      if (finish) begin
        res_keep <= 1'b1;
        res_ovf  <= full;
        if (!full) begin
          count <= count + CW'(1);
        end
        state <= S_DONE;
      end else begin
        case (state)
          S_IDLE: begin
            if (accept) begin
              if (start_set) begin
                count <= '0;
              end
              k <= '0;
              if (is_plane) begin
                state <= S_NN;
              end else begin
                res_keep <= 1'b1;
                res_ovf  <= 1'b0;
                state    <= S_DONE;
              end
            end
          end
          S_NN, S_MM, S_DD: begin
            if (wait_mul && mul_done) begin
              if (k == 2'd2) begin
                k <= '0;
                case (state)
                  S_NN:    state <= S_DL2;
                  S_MM:    state <= S_DD;
                  default: state <= S_DD2;
                endcase
              end else begin
                k <= k + 2'd1;
              end
            end
          end
          S_DL2: begin
            if (wait_mul && mul_done) state <= S_CL2;
          end
          S_CL2: begin
            if (wait_mul && mul_done) state <= S_T;
          end
          S_T: begin
            if (wait_mul && mul_done) begin
              idx   <= '0;
              state <= S_RD;
            end
          end
          S_RD: begin
            k     <= '0;
            state <= S_MM;
          end
          S_DD2: begin
            if (wait_mul && mul_done) state <= S_RHS1;
          end
          S_RHS1: begin
            if (wait_mul && mul_done) begin
              k <= '0;
              if (PW'(lhs) < prod) begin
                state <= S_NM;
              end else begin
                state <= S_NEXT;
              end
            end
          end
          S_NM: begin
            if (wait_mul && mul_done) begin
              if (k == 2'd2) begin
                k <= '0;
                if (acc_new > DW'(0)) begin
                  state <= S_NM2;
                end else begin
                  state <= S_NEXT;
                end
              end else begin
                k <= k + 2'd1;
              end
            end
          end
          S_NM2: begin
            if (wait_mul && mul_done) state <= S_RHS2;
          end
          S_RHS2: begin
            if (wait_mul && mul_done) begin
              if ((PW'(lhs) << ANGLE_SHIFT) > prod) begin
                res_keep <= 1'b0;
                res_ovf  <= 1'b0;
                state    <= S_DONE;
              end else begin
                state <= S_NEXT;
              end
            end
          end
          S_NEXT: begin
            idx   <= idx + CW'(1);
            state <= S_RD;
          end
          S_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid      <= 1'b1;
              keep           <= res_keep;
              store_overflow <= res_ovf;
              state          <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PLANES))
    else $error("plane count above store depth");

  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> wait_mul)
    else $error("multiplier finished without an issued operation");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (idx < count))
    else $error("store read beyond kept planes");

endmodule

`default_nettype wire

@@ rtl/ndpf_mul.sv @@
// shared shift-add multiplier, one multiplier bit per cycle, stops early on zero
`default_nettype none

module ndpf_mul #(
  parameter int AW = 94,
  parameter int BW = 49
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic                  done,
  output logic [AW+BW-1:0]      product
);

  localparam int PW = AW + BW;

  logic          busy;
  logic [PW-1:0] a_sh;
  logic [BW-1:0] b_sh;
  logic [PW-1:0] acc;

  assign done    = busy && (b_sh == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= PW'(a);
      b_sh <= b;
      acc  <= '0;
    end else if (busy && !done) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

`default_nettype wire
